### design/slpc_pkg.sv
// shared types and constants for the slew limited pulse command block
// no dependencies; imported by every module of the block
package slpc_pkg;

    localparam int PULSE_BITS    = 12;
    localparam int SPAN_BITS     = 11;
    localparam int STEP_BITS     = 8;
    localparam int FRAC_BITS     = 14;
    localparam int POWER_BITS    = 16;
    localparam int ACC_BITS      = 28;
    localparam int TGT_BITS      = 14;
    localparam int DIFF_BITS     = 13;
    localparam int CNT_BITS      = 4;
    localparam int REG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;

    localparam logic signed [POWER_BITS-1:0] Q_ONE = 16'sd16384;

    // register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_REST    = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_SPAN    = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_FLOOR   = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_CEILING = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_STEP    = 3'd4;

    // action codes, the unused code behaves as stop
    localparam logic [1:0] ACT_SET_WIDTH = 2'd0;
    localparam logic [1:0] ACT_SET_POWER = 2'd1;
    localparam logic [1:0] ACT_STOP      = 2'd2;

    // register reset values
    localparam logic [PULSE_BITS-1:0] REST_RESET    = 12'd1500;
    localparam logic [SPAN_BITS-1:0]  SPAN_RESET    = 11'd200;
    localparam logic [PULSE_BITS-1:0] FLOOR_RESET   = 12'd1300;
    localparam logic [PULSE_BITS-1:0] CEILING_RESET = 12'd1700;
    localparam logic [STEP_BITS-1:0]  STEP_RESET    = 8'd20;

    typedef struct packed {
        logic [1:0]                   action;
        logic [PULSE_BITS-1:0]        target_width;
        logic signed [POWER_BITS-1:0] power_request;
    } cmd_t;

    typedef struct packed {
        logic [PULSE_BITS-1:0]        pulse_width;
        logic signed [POWER_BITS-1:0] power_level;
    } result_t;

endpackage

### design/slpc_addsub.sv
// shared add/subtract unit of the pulse command sequencer
// depends on slpc_pkg for the accumulator width
module slpc_addsub (
    input  logic [slpc_pkg::ACC_BITS-1:0] a,
    input  logic [slpc_pkg::ACC_BITS-1:0] b,
    input  logic                          sub,
    output logic [slpc_pkg::ACC_BITS-1:0] sum
);
    import slpc_pkg::*;

    logic [ACC_BITS-1:0] b_eff;

    // two's complement subtract: invert and carry in
    assign b_eff = sub ? ~b : b;
    assign sum   = a + b_eff + {{(ACC_BITS-1){1'b0}}, sub};

endmodule

### design/slew_limited_pulse_command.sv
// slew limited motor pulse command, top level with sequencer and registers
// depends on slpc_pkg and slpc_addsub
//
// Each request picks a pulse width target: a direct width, a power command
// (clamped to plus or minus one, target = rest + power * span, truncated
// toward zero) or stop (target = rest; the unused action code also stops).
// The target is clamped to the window from max(floor, rest - span) up to
// min(ceiling, rest + span), lower bound first, and the commanded pulse moves
// toward it by at most step_limit. Each request gives one result: the new
// pulse and its implied power (pulse - rest) * 16384 / span, truncated toward
// zero and saturated to plus or minus 16384 (zero span gives the sign only).
// Sequencing: one request at a time. Multiply, divide and sign step share
// one 28-bit adder: an 11-step shift-add multiply for power commands and a
// 14-step restoring divide for the implied power. A request passes the states
// MUL (power commands only), WIN, SLEW, PREP, DIV, SIGN and FIN; DIV and
// SIGN are skipped when the pulse equals rest or the power saturates.
// in_ready returns in the cycle the result is registered, so the next
// request can enter while the result still waits for out_ready. Registers
// are written when cfg_write is high; the user must write them only while no
// request is in flight, the block does not enforce it; a bad index is ignored.
module slew_limited_pulse_command (
    input  logic                               clk,
    input  logic                               rst_n,
    // command requests
    input  logic                               in_valid,
    output logic                               in_ready,
    input  slpc_pkg::cmd_t                     in_data,
    // result requests
    output logic                               out_valid,
    input  logic                               out_ready,
    output slpc_pkg::result_t                  out_data,
    // register writes
    input  logic                               cfg_write,
    input  logic [slpc_pkg::REG_IDX_BITS-1:0]  cfg_index,
    input  logic [slpc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import slpc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,  // waiting for a request
        S_MUL  = 8'b0000_0010,  // power times span, one bit a cycle
        S_WIN  = 8'b0000_0100,  // truncate target, clamp to safe window
        S_SLEW = 8'b0000_1000,  // step limited move of the pulse
        S_PREP = 8'b0001_0000,  // pulse minus rest, special cases
        S_DIV  = 8'b0010_0000,  // restoring divide, one quotient bit a cycle
        S_SIGN = 8'b0100_0000,  // apply sign to quotient
        S_FIN  = 8'b1000_0000   // hand result to the output register
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [PULSE_BITS-1:0] rest_reg, floor_reg, ceiling_reg;
    logic [SPAN_BITS-1:0]  span_reg;
    logic [STEP_BITS-1:0]  step_reg;

    // working registers
    logic [PULSE_BITS-1:0]        cur_reg, cur_next;
    logic signed [ACC_BITS-1:0]   acc_reg, acc_next;
    logic signed [ACC_BITS-1:0]   mcand_reg, mcand_next;
    logic [SPAN_BITS-1:0]         mplier_reg, mplier_next;
    logic [CNT_BITS-1:0]          cnt_reg, cnt_next;
    logic [PULSE_BITS-1:0]        tgt_reg, tgt_next;
    logic [SPAN_BITS-1:0]         rem_reg, rem_next;
    logic [FRAC_BITS-1:0]         quot_reg, quot_next;
    logic                         neg_reg, neg_next;
    logic signed [POWER_BITS-1:0] pwr_reg, pwr_next;

    // output register
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;

    // shared unit
    logic [ACC_BITS-1:0] alu_a, alu_b, alu_sum;
    logic                alu_sub;

    // combinational helpers
    logic                         in_fire;
    logic signed [POWER_BITS-1:0] p_clamp;
    logic signed [TGT_BITS-1:0]   t_raw, rest_s, span_s, floor_s, ceil_s;
    logic signed [TGT_BITS-1:0]   rest_lo, rest_hi, win_lo, win_hi, t_lo, t_win;
    logic signed [DIFF_BITS-1:0]  delta, step_s, delta_lim, pulse_s;
    logic signed [DIFF_BITS-1:0]  diff, mag;
    logic [PULSE_BITS:0]          rem2;
    logic                         div_ge;
    logic                         out_free;

    slpc_addsub u_addsub (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // power request clamped to plus or minus one
    always_comb
    begin
        if (in_data.power_request > Q_ONE)
        begin
            p_clamp = Q_ONE;
        end
        else if (in_data.power_request < -Q_ONE)
        begin
            p_clamp = -Q_ONE;
        end
        else
        begin
            p_clamp = in_data.power_request;
        end
    end

    // target from accumulator, division by 16384 truncated toward zero
    assign t_raw = acc_reg[ACC_BITS-1 -: TGT_BITS]
                 + TGT_BITS'(acc_reg[ACC_BITS-1] && (acc_reg[FRAC_BITS-1:0] != '0));

    // safe window, lower clamp first
    assign rest_s  = $signed({2'b00, rest_reg});
    assign span_s  = $signed({3'b000, span_reg});
    assign floor_s = $signed({2'b00, floor_reg});
    assign ceil_s  = $signed({2'b00, ceiling_reg});
    assign rest_lo = rest_s - span_s;
    assign rest_hi = rest_s + span_s;
    assign win_lo  = (rest_lo > floor_s) ? rest_lo : floor_s;
    assign win_hi  = (rest_hi < ceil_s) ? rest_hi : ceil_s;
    assign t_lo    = (t_raw < win_lo) ? win_lo : t_raw;
    assign t_win   = (t_lo > win_hi) ? win_hi : t_lo;

    // slew step, result always lies between current pulse and target
    assign delta  = $signed({1'b0, tgt_reg}) - $signed({1'b0, cur_reg});
    assign step_s = $signed({5'b00000, step_reg});
    always_comb
    begin
        priority if (delta > step_s)
        begin
            delta_lim = step_s;
        end
        else if (delta < -step_s)
        begin
            delta_lim = -step_s;
        end
        else
        begin
            delta_lim = delta;
        end
    end
    assign pulse_s = $signed({1'b0, cur_reg}) + delta_lim;

    // pulse relative to rest
    assign diff = $signed({1'b0, cur_reg}) - $signed({1'b0, rest_reg});
    assign mag  = diff[DIFF_BITS-1] ? -diff : diff;

    // divide step: shifted remainder against span
    assign rem2   = {1'b0, rem_reg, 1'b0};
    assign div_ge = !alu_sum[ACC_BITS-1];

    // shared unit operand select
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_MUL:
            begin
                alu_a = acc_reg;
                alu_b = mcand_reg;
            end
            S_DIV:
            begin
                alu_a   = ACC_BITS'(rem2);
                alu_b   = ACC_BITS'(span_reg);
                alu_sub = 1'b1;
            end
            S_SIGN:
            begin
                alu_b   = ACC_BITS'(quot_reg);
                alu_sub = neg_reg;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        cnt_next       = cnt_reg;
        tgt_next       = tgt_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        neg_next       = neg_reg;
        pwr_next       = pwr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (in_data.action == ACT_SET_POWER)
                    begin
                        acc_next    = $signed({2'b00, rest_reg, {FRAC_BITS{1'b0}}});
                        mcand_next  = ACC_BITS'(p_clamp);
                        mplier_next = span_reg;
                        cnt_next    = CNT_BITS'(SPAN_BITS - 1);
                        state_next  = S_MUL;
                    end
                    else if (in_data.action == ACT_SET_WIDTH)
                    begin
                        acc_next   = $signed({2'b00, in_data.target_width,
                                              {FRAC_BITS{1'b0}}});
                        state_next = S_WIN;
                    end
                    else
                    begin
                        // stop and the unused code aim at rest
                        acc_next   = $signed({2'b00, rest_reg, {FRAC_BITS{1'b0}}});
                        state_next = S_WIN;
                    end
                end
            end
            S_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = $signed(alu_sum);
                end
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_WIN;
                end
            end
            S_WIN:
            begin
                tgt_next   = t_win[PULSE_BITS-1:0];
                state_next = S_SLEW;
            end
            S_SLEW:
            begin
                cur_next   = pulse_s[PULSE_BITS-1:0];
                state_next = S_PREP;
            end
            S_PREP:
            begin
                neg_next = diff[DIFF_BITS-1];
                priority if (diff == '0)
                begin
                    pwr_next   = '0;
                    state_next = S_FIN;
                end
                else if (mag[PULSE_BITS-1:0] >= PULSE_BITS'(span_reg))
                begin
                    // also covers zero span: sign only
                    pwr_next   = diff[DIFF_BITS-1] ? -Q_ONE : Q_ONE;
                    state_next = S_FIN;
                end
                else
                begin
                    rem_next   = mag[SPAN_BITS-1:0];
                    quot_next  = '0;
                    cnt_next   = CNT_BITS'(FRAC_BITS - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next  = div_ge ? alu_sum[SPAN_BITS-1:0] : rem2[SPAN_BITS-1:0];
                quot_next = {quot_reg[FRAC_BITS-2:0], div_ge};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                pwr_next   = $signed(alu_sum[POWER_BITS-1:0]);
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // wait until the output register is free
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.pulse_width = cur_reg;
                    out_data_next.power_level = pwr_reg;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cur_reg       <= REST_RESET;
            rest_reg      <= REST_RESET;
            span_reg      <= SPAN_RESET;
            floor_reg     <= FLOOR_RESET;
            ceiling_reg   <= CEILING_RESET;
            step_reg      <= STEP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_REST:    rest_reg    <= cfg_data[PULSE_BITS-1:0];
                    REG_SPAN:    span_reg    <= cfg_data[SPAN_BITS-1:0];
                    REG_FLOOR:   floor_reg   <= cfg_data[PULSE_BITS-1:0];
                    REG_CEILING: ceiling_reg <= cfg_data[PULSE_BITS-1:0];
                    REG_STEP:    step_reg    <= cfg_data[STEP_BITS-1:0];
                    default:     step_reg    <= step_reg;
                endcase
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        cnt_reg      <= cnt_next;
        tgt_reg      <= tgt_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        neg_reg      <= neg_next;
        pwr_reg      <= pwr_next;
        out_data_reg <= out_data_next;
    end

endmodule

### verif/tb_top.sv
// self-checking testbench for slew_limited_pulse_command
// depends on slpc_pkg and the block's rtl; the scoreboard class below predicts each result
module tb_top;
    import slpc_pkg::*;

    // action code with no meaning of its own, the block treats it as stop
    localparam logic [1:0] ACT_SPARE = 2'd3;
    // register indexes past the last register, writes there are dropped
    localparam logic [REG_IDX_BITS-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

    localparam int Q_UNIT       = int'(Q_ONE);
    localparam int PULSE_MAX    = (1 << PULSE_BITS) - 1;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 155;
    localparam int MAX_WAIT     = 13;
    // allow a margin beyond the longest path through the block
    localparam int QUIET_CYCLES = 40;

    // expected pulse and power, kept in step with the block's registers
    class pulse_scoreboard;
        int rest_w  = int'(REST_RESET);
        int span_w  = int'(SPAN_RESET);
        int floor_w = int'(FLOOR_RESET);
        int ceil_w  = int'(CEILING_RESET);
        int step_w  = int'(STEP_RESET);
        int cur_w   = int'(REST_RESET);
        result_t due_pulses[$];
        int mismatches;

        function void note_write(input logic [REG_IDX_BITS-1:0] idx,
                                 input logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_REST:    rest_w  = int'(data);
                REG_SPAN:    span_w  = int'(data[SPAN_BITS-1:0]);
                REG_FLOOR:   floor_w = int'(data);
                REG_CEILING: ceil_w  = int'(data);
                REG_STEP:    step_w  = int'(data[STEP_BITS-1:0]);
                default:     ;
            endcase
        endfunction

        // next pulse after one command, moves cur_w
        function result_t slew_pulse(input cmd_t c);
            int goal, lo, hi, p, nxt, diff, lvl;
            result_t r;
            case (c.action)
                ACT_SET_WIDTH: goal = int'(c.target_width);
                ACT_SET_POWER:
                begin
                    p = int'($signed(c.power_request));
                    if (p > Q_UNIT) p = Q_UNIT;
                    if (p < -Q_UNIT) p = -Q_UNIT;
                    goal = (rest_w * Q_UNIT + p * span_w) / Q_UNIT;
                end
                default: goal = rest_w;
            endcase
            lo = (rest_w - span_w > floor_w) ? rest_w - span_w : floor_w;
            hi = (rest_w + span_w < ceil_w) ? rest_w + span_w : ceil_w;
            // lower clamp first, so an empty window lands on hi
            if (goal < lo) goal = lo;
            if (goal > hi) goal = hi;
            nxt = goal;
            if (nxt > cur_w + step_w) nxt = cur_w + step_w;
            if (nxt < cur_w - step_w) nxt = cur_w - step_w;
            cur_w = nxt;
            diff = nxt - rest_w;
            if (span_w == 0)
                lvl = (diff > 0) ? Q_UNIT : (diff < 0) ? -Q_UNIT : 0;
            else
            begin
                lvl = (diff * Q_UNIT) / span_w;
                if (lvl > Q_UNIT) lvl = Q_UNIT;
                if (lvl < -Q_UNIT) lvl = -Q_UNIT;
            end
            r.pulse_width = nxt[PULSE_BITS-1:0];
            r.power_level = lvl[POWER_BITS-1:0];
            return r;
        endfunction

        function void note_cmd(input cmd_t c);
            due_pulses.push_back(slew_pulse(c));
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (due_pulses.size() == 0)
            begin
                $error("unexpected result: pulse_width %0d power_level %0d",
                       got.pulse_width, got.power_level);
                mismatches++;
                return;
            end
            want = due_pulses.pop_front();
            if (got.pulse_width !== want.pulse_width)
            begin
                $error("pulse_width: expected %0d, got %0d", want.pulse_width, got.pulse_width);
                mismatches++;
            end
            if (got.power_level !== want.power_level)
            begin
                $error("power_level: expected %0d, got %0d", want.power_level, got.power_level);
                mismatches++;
            end
        endfunction

        function int pending();
            return due_pulses.size();
        endfunction
    endclass

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    cmd_t                      in_data   = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    result_t                   out_data;
    logic                      cfg_write = 1'b0;
    logic [REG_IDX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // per phase: when set, that side never idles
    bit tx_calm;
    bit rx_calm;

    pulse_scoreboard sb = new;

    always #1 clk = ~clk;

    slew_limited_pulse_command u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // one command request, with a random gap in front of it
    // returns at the edge where the request is taken
    task automatic send_cmd(input cmd_t c);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        do @(posedge clk); while (!in_ready);
        sb.note_cmd(c);
    endtask

    task automatic send_fields(input logic [1:0] act, input int width, input int power);
        cmd_t c;
        c.action        = act;
        c.target_width  = PULSE_BITS'(width);
        c.power_request = POWER_BITS'(power);
        send_cmd(c);
    endtask

    // only called right at the edge a request was taken
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // leaves cfg_write high, the caller of the last write lowers it
    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.note_write(idx, data);
    endtask

    // full register set plus one write to an unused index; block must be idle
    task automatic apply_settings(input int rest_v, input int span_v, input int floor_v,
                                  input int ceil_v, input int step_v);
        write_reg(REG_REST, CFG_DATA_BITS'(rest_v));
        write_reg(REG_SPAN, CFG_DATA_BITS'(span_v));
        write_reg(REG_SPARE_LO + REG_IDX_BITS'($urandom_range(0, REG_SPARE_HI - REG_SPARE_LO)),
                  CFG_DATA_BITS'($urandom()));
        write_reg(REG_FLOOR, CFG_DATA_BITS'(floor_v));
        write_reg(REG_CEILING, CFG_DATA_BITS'(ceil_v));
        write_reg(REG_STEP, CFG_DATA_BITS'(step_v));
        cfg_write <= 1'b0;
    endtask

    function automatic int pick_extreme(input int lo, input int hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // result side: random stall before each result, stall-free stretches per phase
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(out_data);
        end
    end

    initial
    begin : stimulus
        cmd_t cmd;
        cmd_t prev_cmd;
        int   rest_v, span_v, floor_v, ceil_v, step_v, reach, roll;

        tx_calm = 1'b0;
        rx_calm = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: width extremes, every action, power past full scale
        send_fields(ACT_SET_WIDTH, PULSE_MAX, 0);
        send_fields(ACT_SET_WIDTH, 0, -1);
        send_fields(ACT_SET_WIDTH, 0, 0);
        send_fields(ACT_SET_POWER, PULSE_MAX, 0);
        send_fields(ACT_STOP, 1234, 32767);
        send_fields(ACT_SPARE, PULSE_MAX, -32768);
        send_fields(ACT_SET_POWER, 0, -32768);
        send_fields(ACT_SET_POWER, 0, 32767);
        send_fields(ACT_SET_POWER, 0, -Q_UNIT);
        send_fields(ACT_SET_POWER, 0, Q_UNIT);
        send_fields(ACT_SET_WIDTH, PULSE_MAX, 0);
        send_fields(ACT_SET_WIDTH, PULSE_MAX, 0);
        drain_results();

        // zero span and zero step: pulse stuck above rest, power is the sign only
        apply_settings(1500, 0, 1300, 1700, 0);
        send_fields(ACT_SET_POWER, 0, 9000);
        send_fields(ACT_SET_WIDTH, 0, 0);
        drain_results();

        // zero span, full step: window collapses onto rest
        apply_settings(1500, 0, 1300, 1700, 255);
        send_fields(ACT_STOP, 0, 0);
        drain_results();

        // widest span from the top rest, implied power saturates low
        apply_settings(PULSE_MAX, 2047, 0, PULSE_MAX, 255);
        send_fields(ACT_SET_WIDTH, 0, 0);
        send_fields(ACT_SET_POWER, 0, 32767);
        drain_results();

        // empty window, floor above ceiling, target ends on the upper bound
        apply_settings(0, 2047, PULSE_MAX, 0, 255);
        send_fields(ACT_SET_WIDTH, 2000, 0);
        send_fields(ACT_SET_POWER, 0, -32768);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);

            if ($urandom_range(0, 3) != 0)
            begin
                // usable window around rest, mostly small steps so slewing shows
                rest_v  = $urandom_range(400, 3600);
                span_v  = $urandom_range(1, 300);
                floor_v = rest_v - int'($urandom_range(0, span_v + 60));
                ceil_v  = rest_v + int'($urandom_range(0, span_v + 60));
                step_v  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(1, 40);
            end
            else
            begin
                rest_v  = pick_extreme(0, PULSE_MAX);
                span_v  = pick_extreme(0, 2047);
                floor_v = pick_extreme(0, PULSE_MAX);
                ceil_v  = pick_extreme(0, PULSE_MAX);
                step_v  = pick_extreme(0, 255);
            end
            // junk above the narrow registers must be dropped by the block
            span_v = span_v | int'($urandom_range(0, 1) << SPAN_BITS);
            step_v = step_v | int'($urandom_range(0, 15) << STEP_BITS);
            apply_settings(rest_v, span_v, floor_v, ceil_v, step_v);

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // repeating a command lets the pulse settle on its target
                if (i > 0 && $urandom_range(0, 2) == 0)
                    cmd = prev_cmd;
                else
                begin
                    roll = $urandom_range(0, 99);
                    cmd.action = (roll < 40) ? ACT_SET_WIDTH :
                                 (roll < 80) ? ACT_SET_POWER :
                                 (roll < 92) ? ACT_STOP : ACT_SPARE;
                    if ($urandom_range(0, 3) == 0)
                        cmd.target_width = PULSE_BITS'($urandom());
                    else
                    begin
                        // mostly around the window so both clamps and the interior get hit
                        reach = sb.rest_w - sb.span_w - 64
                              + int'($urandom_range(0, 2 * sb.span_w + 128));
                        if (reach < 0) reach = 0;
                        if (reach > PULSE_MAX) reach = PULSE_MAX;
                        cmd.target_width = PULSE_BITS'(reach);
                    end
                    if ($urandom_range(0, 7) == 0)
                        cmd.power_request = POWER_BITS'($urandom());
                    else
                        cmd.power_request = POWER_BITS'(int'($urandom_range(0, 2 * Q_UNIT))
                                                        - Q_UNIT);
                end
                send_cmd(cmd);
                prev_cmd = cmd;
                // now and then hold off until every result is back
                if (i < PHASE_ITEMS - 1 && $urandom_range(0, 63) == 0)
                    drain_results();
            end
        end

        drain_results();
        // stray results after the last one would show up here
        repeat (QUIET_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // about ten times the slowest legal run
    initial
    begin : watchdog
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
